// ===== hw/rtl/heap_allocation_tracker_unit_assert.svh =====
// Assertion macros shared by the tracker RTL.
// Every check is clocked on clk and held off while rst is high.
`ifndef HEAP_ALLOCATION_TRACKER_UNIT_ASSERT_SVH
`define HEAP_ALLOCATION_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds in the same cycle.
`define HAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define HAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hat_pkg.sv =====
`default_nettype none

package hat_pkg;

  // Live table organization: entries are grouped into rows of lanes, and one
  // row of addresses is fetched and compared per cycle during the scan.
  localparam int TABLE_ENTRIES = 256;
  localparam int ROW_LANES     = 32;
  localparam int ROWS          = TABLE_ENTRIES / ROW_LANES;
  localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
  localparam int LANE_BITS     = $clog2(ROW_LANES);
  localparam int ROW_BITS      = $clog2(ROWS);
  localparam int BLOCK_BITS    = $clog2(TABLE_ENTRIES + 1);

  // Field widths.
  localparam int ADDR_BITS  = 48;
  localparam int SIZE_BITS  = 32;
  localparam int BYTES_BITS = 48;
  localparam int COUNT_BITS = 32;
  localparam int TOTAL_BITS = 64;
  localparam int AVG_BITS   = 16;
  localparam int PROD_BITS  = AVG_BITS + COUNT_BITS;

  // Configuration port.
  localparam int CFG_DATA_BITS  = 48;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_LEAK_HIGH     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LEAK_CRITICAL = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LARGE_ALLOC   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHURN_AVG     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHURN_COUNT   = 3'd4;

  localparam logic [BYTES_BITS-1:0] RST_LEAK_HIGH     = 48'd1048576;
  localparam logic [BYTES_BITS-1:0] RST_LEAK_CRITICAL = 48'd16777216;
  localparam logic [SIZE_BITS-1:0]  RST_LARGE_ALLOC   = 32'd67108864;
  localparam logic [AVG_BITS-1:0]   RST_CHURN_AVG     = 16'd128;
  localparam logic [COUNT_BITS-1:0] RST_CHURN_COUNT   = 32'd1000;

  // Event codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Leak severity classes.
  localparam logic [1:0] SEV_NONE     = 2'd0;
  localparam logic [1:0] SEV_MEDIUM   = 2'd1;
  localparam logic [1:0] SEV_HIGH     = 2'd2;
  localparam logic [1:0] SEV_CRITICAL = 2'd3;

  typedef logic [ROW_LANES*ADDR_BITS-1:0] addr_row_t;

  // Result of comparing one fetched row against the search key.
  typedef struct packed {
    logic                 hit;
    logic [LANE_BITS-1:0] hit_lane;
    logic                 free;
    logic [LANE_BITS-1:0] free_lane;
  } row_match_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hat_ram.sv =====
`default_nettype none

module hat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hat_row_match.sv =====
`default_nettype none

module hat_row_match
  import hat_pkg::*;
(
  input  wire addr_row_t              row_addr,
  input  wire logic [ROW_LANES-1:0]   row_valid,
  input  wire logic [ADDR_BITS-1:0]   key,
  output row_match_t                  match
);

  logic [ROW_LANES-1:0] hit_vec;

  always_comb begin
    for (int l = 0; l < ROW_LANES; l++) begin
      hit_vec[l] = row_valid[l] && (row_addr[l*ADDR_BITS +: ADDR_BITS] == key);
    end
  end

  // Lowest lane wins for both the match and the free slot.
  always_comb begin
    match = '0;
    for (int l = ROW_LANES - 1; l >= 0; l--) begin
      if (hit_vec[l]) begin
        match.hit      = 1'b1;
        match.hit_lane = LANE_BITS'(l);
      end
      if (!row_valid[l]) begin
        match.free      = 1'b1;
        match.free_lane = LANE_BITS'(l);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/heap_allocation_tracker_unit.sv =====
`default_nettype none
// Channel   Signals                                 Handshake
// -------   -------------------------------------   ---------------------------------
// event     operation, address, size                start high while busy is low
// result    current_bytes .. table_overflow         done high for one cycle
// config    cfg_write_en, cfg_index, cfg_data       cfg_write_en high, taken at once
//
// An item keeps the block busy until it returns to idle, and no new item is
// accepted before then: the scan streams the eight rows of the address memory
// through the 32-lane comparator, then the look-up state fetches the hit size
// and the free row, UPD1 and UPD2 update the statistics and ST_FLAG derives the flags.
// The result is presented with done in the cycle after that, while the block
// is already idle, so a new item may be accepted in the same cycle.
// Reset is synchronous and clears the valid bits and all statistics at once;
// no clearing pass is needed. The receiver cannot stall the result.

module heap_allocation_tracker_unit
  import hat_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,

  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      operation,
  input  wire logic [ADDR_BITS-1:0]      address,
  input  wire logic [SIZE_BITS-1:0]      size,

  input  wire logic                      cfg_write_en,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,

  output logic                           done,
  output logic [BYTES_BITS-1:0]          current_bytes,
  output logic [BYTES_BITS-1:0]          high_water_bytes,
  output logic [BYTES_BITS-1:0]          live_bytes,
  output logic [BLOCK_BITS-1:0]          live_blocks,
  output logic [COUNT_BITS-1:0]          alloc_count,
  output logic [COUNT_BITS-1:0]          free_count,
  output logic [COUNT_BITS-1:0]          invalid_free_count,
  output logic [SIZE_BITS-1:0]           largest_alloc,
  output logic [1:0]                     leak_severity,
  output logic                           churn_flag,
  output logic                           large_alloc_flag,
  output logic                           table_overflow
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_LOOK = 3'd2;
  localparam logic [2:0] ST_UPD1 = 3'd3;
  localparam logic [2:0] ST_UPD2 = 3'd4;
  localparam logic [2:0] ST_FLAG = 3'd5;

  logic [2:0] state;

  // Configuration registers.
  logic [BYTES_BITS-1:0] leak_high_limit;
  logic [BYTES_BITS-1:0] leak_critical_limit;
  logic [SIZE_BITS-1:0]  large_alloc_limit;
  logic [AVG_BITS-1:0]   churn_avg_limit;
  logic [COUNT_BITS-1:0] churn_count_limit;

  // The item being processed.
  logic                  op_q;
  logic [ADDR_BITS-1:0]  addr_q;
  logic [SIZE_BITS-1:0]  size_q;

  // Search results gathered over the row scan.
  logic [ROW_BITS-1:0]   row;
  logic                  hit_found;
  logic [SLOT_BITS-1:0]  hit_idx;
  logic                  free_found;
  logic [SLOT_BITS-1:0]  free_idx;
  logic                  store_add;

  // Live table valid bits, one per entry, cleared by reset.
  logic [ROWS-1:0][ROW_LANES-1:0] valid;

  // Running statistics.
  logic [BYTES_BITS-1:0] current_total;
  logic [BYTES_BITS-1:0] peak_total;
  logic [BYTES_BITS-1:0] live_total;
  logic [TOTAL_BITS-1:0] allocated_total;
  logic [COUNT_BITS-1:0] alloc_cnt;
  logic [COUNT_BITS-1:0] free_cnt;
  logic [COUNT_BITS-1:0] invalid_cnt;
  logic [SIZE_BITS-1:0]  largest_seen;
  logic                  overflow_seen;
  logic [BLOCK_BITS-1:0] blocks_in_use;
  logic [PROD_BITS-1:0]  churn_product;
  logic [1:0]            sev;
  logic                  churn;
  logic                  big_alloc;

  // Memories: addresses in rows of lanes, sizes one entry per word.
  logic                 addr_we;
  logic [ROW_BITS-1:0]  addr_raddr;
  addr_row_t            addr_rdata;
  addr_row_t            addr_wdata;
  logic                 size_we;
  logic [SLOT_BITS-1:0] size_waddr;
  logic [SIZE_BITS-1:0] size_rdata;

  row_match_t           match;

  hat_ram #(
    .WIDTH ($bits(addr_row_t)),
    .DEPTH (ROWS)
  ) u_addr_ram (
    .clk   (clk),
    .we    (addr_we),
    .waddr (free_idx[SLOT_BITS-1:LANE_BITS]),
    .wdata (addr_wdata),
    .raddr (addr_raddr),
    .rdata (addr_rdata)
  );

  hat_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (TABLE_ENTRIES)
  ) u_size_ram (
    .clk   (clk),
    .we    (size_we),
    .waddr (size_waddr),
    .wdata (size_q),
    .raddr (hit_idx),
    .rdata (size_rdata)
  );

  hat_row_match u_row_match (
    .row_addr  (addr_rdata),
    .row_valid (valid[row]),
    .key       (addr_q),
    .match     (match)
  );

  assign busy = (state != ST_IDLE);

  // Read address of the address memory. While idle it points at row 0 so the
  // first row is already on its way when an item is accepted. During the scan
  // it runs one row ahead of the compare, and afterwards it fetches the row
  // that will receive a new entry.
  always_comb begin
    unique case (state)
      ST_SCAN: addr_raddr = row + ROW_BITS'(1);
      ST_LOOK: addr_raddr = free_idx[SLOT_BITS-1:LANE_BITS];
      default: addr_raddr = '0;
    endcase
  end

  // A new entry is merged into its row, the other lanes keep their contents.
  always_comb begin
    for (int l = 0; l < ROW_LANES; l++) begin
      addr_wdata[l*ADDR_BITS +: ADDR_BITS] =
        (LANE_BITS'(l) == free_idx[LANE_BITS-1:0]) ? addr_q
                                                   : addr_rdata[l*ADDR_BITS +: ADDR_BITS];
    end
  end

  // Table writes happen in the first update cycle of an allocate. A repeated
  // address only replaces the size; a new address takes the free slot.
  assign addr_we    = (state == ST_UPD1) && (op_q == OP_ALLOC) && !hit_found && free_found;
  assign size_we    = (state == ST_UPD1) && (op_q == OP_ALLOC) && (hit_found || free_found);
  assign size_waddr = hit_found ? hit_idx : free_idx;

  // Arithmetic for the update cycles. Sums carry one extra bit to detect
  // saturation; subtractions stop at zero.
  logic [BYTES_BITS-1:0] old_size_w;
  logic [BYTES_BITS:0]   cur_sum;
  logic [TOTAL_BITS:0]   tot_sum;
  logic [BYTES_BITS:0]   live_sum;
  logic [BYTES_BITS-1:0] cur_sat;
  logic [TOTAL_BITS-1:0] tot_sat;
  logic [BYTES_BITS-1:0] live_sat;
  logic [BYTES_BITS-1:0] cur_floor;
  logic [BYTES_BITS-1:0] live_floor;

  assign old_size_w = {{(BYTES_BITS - SIZE_BITS){1'b0}}, size_rdata};
  assign cur_sum    = {1'b0, current_total} + {{(BYTES_BITS + 1 - SIZE_BITS){1'b0}}, size_q};
  assign tot_sum    = {1'b0, allocated_total} + {{(TOTAL_BITS + 1 - SIZE_BITS){1'b0}}, size_q};
  assign live_sum   = {1'b0, live_total} + {{(BYTES_BITS + 1 - SIZE_BITS){1'b0}}, size_q};
  assign cur_sat    = cur_sum[BYTES_BITS] ? '1 : cur_sum[BYTES_BITS-1:0];
  assign tot_sat    = tot_sum[TOTAL_BITS] ? '1 : tot_sum[TOTAL_BITS-1:0];
  assign live_sat   = live_sum[BYTES_BITS] ? '1 : live_sum[BYTES_BITS-1:0];
  assign cur_floor  = (current_total > old_size_w) ? current_total - old_size_w : '0;
  assign live_floor = (live_total > old_size_w) ? live_total - old_size_w : '0;

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      leak_high_limit     <= RST_LEAK_HIGH;
      leak_critical_limit <= RST_LEAK_CRITICAL;
      large_alloc_limit   <= RST_LARGE_ALLOC;
      churn_avg_limit     <= RST_CHURN_AVG;
      churn_count_limit   <= RST_CHURN_COUNT;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_LEAK_HIGH:     leak_high_limit     <= cfg_data[BYTES_BITS-1:0];
        CFG_LEAK_CRITICAL: leak_critical_limit <= cfg_data[BYTES_BITS-1:0];
        CFG_LARGE_ALLOC:   large_alloc_limit   <= cfg_data[SIZE_BITS-1:0];
        CFG_CHURN_AVG:     churn_avg_limit     <= cfg_data[AVG_BITS-1:0];
        CFG_CHURN_COUNT:   churn_count_limit   <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Item payload and search results; no reset needed.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      op_q   <= operation;
      addr_q <= address;
      size_q <= size;
    end
    if (state == ST_SCAN) begin
      if (!hit_found && match.hit) begin
        hit_idx <= {row, match.hit_lane};
      end
      if (!free_found && match.free) begin
        free_idx <= {row, match.free_lane};
      end
    end
    if (state == ST_UPD2) begin
      churn_product <= PROD_BITS'(churn_avg_limit) * PROD_BITS'(alloc_cnt);
    end
  end

  // Sequencer and statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      row             <= '0;
      hit_found       <= 1'b0;
      free_found      <= 1'b0;
      store_add       <= 1'b0;
      valid           <= '0;
      current_total   <= '0;
      peak_total      <= '0;
      live_total      <= '0;
      allocated_total <= '0;
      alloc_cnt       <= '0;
      free_cnt        <= '0;
      invalid_cnt     <= '0;
      largest_seen    <= '0;
      overflow_seen   <= 1'b0;
      blocks_in_use   <= '0;
      sev             <= SEV_NONE;
      churn           <= 1'b0;
      big_alloc       <= 1'b0;
      done            <= 1'b0;
    end else begin
      // The result strobe follows the flag cycle.
      done <= (state == ST_FLAG);
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            row        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          // Addresses are unique in the table, so the first hit is the only one.
          if (match.hit) begin
            hit_found <= 1'b1;
          end
          if (match.free) begin
            free_found <= 1'b1;
          end
          row <= row + ROW_BITS'(1);
          if (row == ROW_BITS'(ROWS - 1)) begin
            state <= ST_LOOK;
          end
        end

        ST_LOOK: begin
          state <= ST_UPD1;
        end

        ST_UPD1: begin
          // An allocate that lands in the table adds its size in the next cycle.
          store_add <= (op_q == OP_ALLOC) && (hit_found || free_found);
          if (op_q == OP_ALLOC) begin
            if (alloc_cnt != '1) begin
              alloc_cnt <= alloc_cnt + COUNT_BITS'(1);
            end
            allocated_total <= tot_sat;
            current_total   <= cur_sat;
            if (size_q > largest_seen) begin
              largest_seen <= size_q;
            end
            if (hit_found) begin
              live_total <= live_floor;
            end else if (free_found) begin
              valid[free_idx[SLOT_BITS-1:LANE_BITS]][free_idx[LANE_BITS-1:0]] <= 1'b1;
              blocks_in_use <= blocks_in_use + BLOCK_BITS'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
          end else if (hit_found) begin
            if (free_cnt != '1) begin
              free_cnt <= free_cnt + COUNT_BITS'(1);
            end
            current_total <= cur_floor;
            live_total    <= live_floor;
            valid[hit_idx[SLOT_BITS-1:LANE_BITS]][hit_idx[LANE_BITS-1:0]] <= 1'b0;
            blocks_in_use <= blocks_in_use - BLOCK_BITS'(1);
          end else begin
            if (invalid_cnt != '1) begin
              invalid_cnt <= invalid_cnt + COUNT_BITS'(1);
            end
          end
          state <= ST_UPD2;
        end

        ST_UPD2: begin
          if (current_total > peak_total) begin
            peak_total <= current_total;
          end
          if (store_add) begin
            live_total <= live_sat;
          end
          state <= ST_FLAG;
        end

        ST_FLAG: begin
          if (live_total == '0) begin
            sev <= SEV_NONE;
          end else if (live_total > leak_critical_limit) begin
            sev <= SEV_CRITICAL;
          end else if (live_total > leak_high_limit) begin
            sev <= SEV_HIGH;
          end else begin
            sev <= SEV_MEDIUM;
          end
          churn <= (alloc_cnt != '0) && (alloc_cnt > churn_count_limit) &&
                   (allocated_total < TOTAL_BITS'(churn_product));
          big_alloc <= (largest_seen > large_alloc_limit);
          state     <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The result ports show the registered statistics; they only change while
  // an item is in flight, so they are stable in the cycle marked by done.
  assign current_bytes      = current_total;
  assign high_water_bytes   = peak_total;
  assign live_bytes         = live_total;
  assign live_blocks        = blocks_in_use;
  assign alloc_count        = alloc_cnt;
  assign free_count         = free_cnt;
  assign invalid_free_count = invalid_cnt;
  assign largest_alloc      = largest_seen;
  assign leak_severity      = sev;
  assign churn_flag         = churn;
  assign large_alloc_flag   = big_alloc;
  assign table_overflow     = overflow_seen;

`include "heap_allocation_tracker_unit_assert.svh"

  // The block count must always agree with the number of set valid bits.
  `HAT_ASSERT_NOW(a_blocks_match_valid, 1'b1, blocks_in_use == $countones(valid), "bad count")
  // A result is only presented while the sequencer is idle.
  `HAT_ASSERT_NOW(a_done_when_idle, done, state == ST_IDLE, "strobe outside idle")
  // Flag derivation is always followed by the result strobe.
  `HAT_ASSERT_NEXT(a_flag_then_done, state == ST_FLAG, done, "flag without result")
  // An accepted item always starts the row scan at row zero.
  `HAT_ASSERT_NEXT(a_accept_scans, start && !busy, state == ST_SCAN && row == '0, "no scan")

endmodule

`default_nettype wire
